### design/pstc_pkg.sv
// pstc_pkg: shared constants, codes and types of the per-source IP traffic counter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package pstc_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_IPV6 = 16'h86DD;
   localparam logic [15:0] MIN_LEN_IPV4 = 16'd34;
   localparam logic [15:0] MIN_LEN_IPV6 = 16'd54;

   // Bucket span in ns; quotient always fits in 31 bits.
   localparam logic [63:0] BUCKET_SPAN_NS = 64'd10000000000;
   // 10^10 = 2^10 * 5^10: shift out the power of two, then divide by 5^10.
   localparam logic [23:0] BUCKET_ODD = 24'd9765625;
   // floor(2^64 / 10^10), applied to bits [63:32] of time_ns.
   localparam logic [30:0] BUCKET_RECIP = 31'd1844674407;

   typedef enum logic [1:0] {
      ST_IGNORED = 2'd0,
      ST_HIT     = 2'd1,
      ST_NEW     = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SCAN,
      B_WAIT,
      B_DONE
   } back_state_type;

   // One classified frame, as queued between front and back.
   typedef struct packed {
      logic        is_ip;
      logic        is_v6;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [15:0] packet_len;
      logic [63:0] time_ns;
   } item_type;

   typedef struct packed {
      logic        is_v6;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [63:0] packets;
      logic [63:0] bytes;
      logic [31:0] bucket;
   } entry_type;

   // Queue handshake toward the back part.
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

### design/pstc_front.sv
// pstc_front: accepts frame summaries, classifies them and queues them (2 deep).
// Depends on pstc_pkg.
`timescale 1ns / 1ps
module pstc_front
   import pstc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [15:0]   req_ether_type,
   input  logic [15:0]   req_captured_len,
   input  logic [63:0]   req_src_addr_hi,
   input  logic [63:0]   req_src_addr_lo,
   input  logic [15:0]   req_packet_len,
   input  logic [63:0]   req_time_ns,
   output queue_out_type q_out,
   input  logic          q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       v4, v6;
   item_type   cls;

   always_comb begin
      v4 = (req_ether_type == ETH_IPV4) && (req_captured_len >= MIN_LEN_IPV4);
      v6 = (req_ether_type == ETH_IPV6) && (req_captured_len >= MIN_LEN_IPV6);
      cls.is_ip      = v4 || v6;
      cls.is_v6      = v6;
      cls.addr_hi    = v6 ? req_src_addr_hi : 64'd0;
      cls.addr_lo    = v6 ? req_src_addr_lo : {32'd0, req_src_addr_lo[31:0]};
      cls.packet_len = req_packet_len;
      cls.time_ns    = req_time_ns;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = slot_ff[rd_ptr_ff];

endmodule

### design/pstc_div.sv
// pstc_div: time_ns / 10^10 by reciprocal multiplication.
// Depends on pstc_pkg.
`timescale 1ns / 1ps
module pstc_div
   import pstc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   output logic        done,
   output logic [31:0] quotient
);

   logic [53:0] num_ff, num_in;
   logic [62:0] prod_ff, prod_in;
   logic [53:0] rem_ff, rem_in;
   logic [31:0] q_ff, q_in;
   logic [2:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        fix;

   // Steps: estimate from the top 32 bits of the shifted time (low by at most
   // two), multiply back, take the remainder, then two correction passes.
   always_comb begin
      fix     = rem_ff >= {30'd0, BUCKET_ODD};
      num_in  = num_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = dividend[63:10];
         step_in = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         case (step_ff)
            3'd0: begin
               prod_in = {31'd0, num_ff[53:22]} * {32'd0, BUCKET_RECIP};
            end
            3'd1: begin
               q_in    = {1'b0, prod_ff[62:32]};
               prod_in = {32'd0, prod_ff[62:32]} * {39'd0, BUCKET_ODD};
            end
            3'd2: begin
               rem_in = num_ff - prod_ff[53:0];
            end
            default: begin
               if (fix) begin
                  q_in   = q_ff + 32'd1;
                  rem_in = rem_ff - {30'd0, BUCKET_ODD};
               end
               if (step_ff == 3'd4) begin
                  busy_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      num_ff  <= num_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   assign done     = !busy_ff;
   assign quotient = q_ff;

endmodule

### design/pstc_back.sv
// pstc_back: table scan, counter update and result register of the traffic counter.
// Depends on pstc_pkg and pstc_div.
`timescale 1ns / 1ps
module pstc_back
   import pstc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type q_in,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic [63:0]   rsp_packet_count,
   output logic [63:0]   rsp_byte_count,
   output logic [31:0]   rsp_time_bucket
);

   back_state_type state_ff, state_in;

   entry_type  mem [TABLE_ENTRIES];
   entry_type  rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic       mem_we;
   entry_type  wr_data;

   item_type   cur_ff, cur_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic       cmp_ok_ff, cmp_ok_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   status_type status_ff, status_in;
   logic [63:0] pk_ff, pk_in;
   logic [63:0] by_ff, by_in;
   logic [31:0] bk_ff, bk_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_pk_ff, rsp_pk_in;
   logic [63:0] rsp_by_ff, rsp_by_in;
   logic [31:0] rsp_bk_ff, rsp_bk_in;

   logic        div_start, div_done;
   logic [31:0] div_q;
   logic        match, miss, more, out_free;

   pstc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_in.item.time_ns),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      match = cmp_ok_ff && (rd_data_ff.is_v6 == cur_ff.is_v6)
              && (rd_data_ff.addr_hi == cur_ff.addr_hi)
              && (rd_data_ff.addr_lo == cur_ff.addr_lo);
      more  = idx_ff < used_ff;
      miss  = !match && !cmp_ok_ff && !more;
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_in.valid) begin
               state_in = q_in.item.is_ip ? B_SCAN : B_DONE;
            end
         end
         B_SCAN: begin
            if (match) begin
               state_in = B_WAIT;
            end else if (miss) begin
               state_in = (used_ff >= CNT_W'(TABLE_ENTRIES)) ? B_DONE : B_WAIT;
            end
         end
         B_WAIT: begin
            if (div_done) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      q_pop      = 1'b0;
      div_start  = 1'b0;
      mem_we     = 1'b0;
      cur_in     = cur_ff;
      used_in    = used_ff;
      idx_in     = idx_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_ok_in  = 1'b0;
      slot_in    = slot_ff;
      status_in  = status_ff;
      pk_in      = pk_ff;
      by_in      = by_ff;
      bk_in      = bk_ff;
      rd_addr    = idx_ff[IDX_W-1:0];
      wr_data    = '{is_v6: cur_ff.is_v6, addr_hi: cur_ff.addr_hi,
                     addr_lo: cur_ff.addr_lo, packets: pk_ff, bytes: by_ff,
                     bucket: div_q};
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pk_in     = rsp_pk_ff;
      rsp_by_in     = rsp_by_ff;
      rsp_bk_in     = rsp_bk_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_in.valid) begin
               q_pop     = 1'b1;
               cur_in    = q_in.item;
               idx_in    = '0;
               div_start = q_in.item.is_ip;
               status_in = ST_IGNORED;
               pk_in     = 64'd0;
               by_in     = 64'd0;
               bk_in     = 32'd0;
            end
         end
         B_SCAN: begin
            if (match) begin
               slot_in   = cmp_idx_ff;
               status_in = ST_HIT;
               pk_in     = rd_data_ff.packets + 64'd1;
               by_in     = rd_data_ff.bytes + {48'd0, cur_ff.packet_len};
            end else if (miss) begin
               if (used_ff >= CNT_W'(TABLE_ENTRIES)) begin
                  status_in = ST_FULL;
               end else begin
                  slot_in   = used_ff[IDX_W-1:0];
                  status_in = ST_NEW;
                  pk_in     = 64'd1;
                  by_in     = {48'd0, cur_ff.packet_len};
                  used_in   = used_ff + CNT_W'(1);
               end
            end else if (more) begin
               // keep one read in flight, compare the previous one
               cmp_ok_in  = 1'b1;
               cmp_idx_in = idx_ff[IDX_W-1:0];
               idx_in     = idx_ff + CNT_W'(1);
            end
         end
         B_WAIT: begin
            if (div_done) begin
               mem_we = 1'b1;
               bk_in  = div_q;
            end
         end
         B_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pk_in     = pk_ff;
               rsp_by_in     = by_ff;
               rsp_bk_in     = bk_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot_ff] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         used_ff      <= '0;
         cmp_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_ok_ff    <= cmp_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      pk_ff         <= pk_in;
      by_ff         <= by_in;
      bk_ff         <= bk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pk_ff     <= rsp_pk_in;
      rsp_by_ff     <= rsp_by_in;
      rsp_bk_ff     <= rsp_bk_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_packet_count = rsp_pk_ff;
   assign rsp_byte_count   = rsp_by_ff;
   assign rsp_time_bucket  = rsp_bk_ff;

endmodule

### design/per_source_ip_traffic_counter.sv
// per_source_ip_traffic_counter: top level, joins the front queue and the back table engine.
// Depends on pstc_pkg, pstc_front, pstc_back (and pstc_div below it).
//
// Usage:
//  - req_* carries one frame summary per transfer (valid/stall). IPv4 frames
//    (0x0800, >= 34 bytes) and IPv6 frames (0x86DD, >= 54 bytes) are counted
//    per family and source address; anything else returns status ignored.
//  - rsp_* returns exactly one result per request, in order: status, the
//    entry's packet and byte counters after the update, and the 10 s bucket.
//  - The front holds a 2-deep queue, so requests keep flowing while the back
//    works on an earlier frame and a result waits in the output register.
//  - A counted frame scans the table one entry per cycle from slot 0 through
//    the single read port, up to a hit, or over all used slots (up to 1024)
//    for a new entry or a drop. The 5-step reciprocal divider runs alongside the
//    scan; a frame dropped at a full table does not wait for it.
//  - One frame at a time in the back. Reset empties the queue and zeroes the
//    fill count, which invalidates the table at once (occupied slots are
//    always 0 .. used-1).
//  - A stalled result holds on rsp_*; the back then waits and the queue fills,
//    after which req_stall rises.
`timescale 1ns / 1ps
module per_source_ip_traffic_counter
   import pstc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_ether_type,
   input  logic [15:0] req_captured_len,
   input  logic [63:0] req_src_addr_hi,
   input  logic [63:0] req_src_addr_lo,
   input  logic [15:0] req_packet_len,
   input  logic [63:0] req_time_ns,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_packet_count,
   output logic [63:0] rsp_byte_count,
   output logic [31:0] rsp_time_bucket
);

   queue_out_type q_out;
   logic          q_pop;

   // front: classify and buffer
   pstc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ether_type   (req_ether_type),
      .req_captured_len (req_captured_len),
      .req_src_addr_hi  (req_src_addr_hi),
      .req_src_addr_lo  (req_src_addr_lo),
      .req_packet_len   (req_packet_len),
      .req_time_ns      (req_time_ns),
      .q_out            (q_out),
      .q_pop            (q_pop)
   );

   // back: lookup, insert, count, respond
   pstc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_in             (q_out),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_packet_count (rsp_packet_count),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_time_bucket  (rsp_time_bucket)
   );

   // Frames not counted report all-zero values.
   a_zero_when_uncounted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_IGNORED || rsp_status == ST_FULL)
      |-> (rsp_packet_count == 64'd0 && rsp_byte_count == 64'd0
           && rsp_time_bucket == 32'd0))
      else $error("uncounted frame reported nonzero values");

   // A freshly inserted entry has seen exactly one packet.
   a_new_is_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NEW |-> rsp_packet_count == 64'd1)
      else $error("new entry packet count is not one");

   // Pop only from a non-empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_out.valid)
      else $error("queue popped while empty");

   // The queue is empty right after reset.
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("stall asserted right after reset");

endmodule

### sim/pstc_scoreboard.sv
// pstc_scoreboard: watches both channels of the traffic counter, predicts each result
// from its own copy of the table and compares. Depends on pstc_pkg.
`timescale 1ns / 1ps
module pstc_scoreboard
   import pstc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_ether_type,
   input  logic [15:0] req_captured_len,
   input  logic [63:0] req_src_addr_hi,
   input  logic [63:0] req_src_addr_lo,
   input  logic [15:0] req_packet_len,
   input  logic [63:0] req_time_ns,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [63:0] rsp_packet_count,
   input  logic [63:0] rsp_byte_count,
   input  logic [31:0] rsp_time_bucket,
   output int          fail_count,
   output int          pending,
   output int          seen_counts [4]
);

   typedef struct packed {
      status_type  status;
      logic [63:0] packets;
      logic [63:0] bytes;
      logic [31:0] bucket;
   } tally_type;

   entry_type   flow_table [TABLE_ENTRIES];
   int          flows_used;
   tally_type   tally_queue [$];

   assign pending = tally_queue.size();

   function automatic tally_type count_frame(input logic [15:0] etype, input logic [15:0] caplen,
                                             input logic [63:0] ahi, input logic [63:0] alo,
                                             input logic [15:0] plen, input logic [63:0] now);
      tally_type t;
      logic      v6;
      int        slot;
      t = '0;
      t.status = ST_IGNORED;
      if (etype == ETH_IPV4 && caplen >= MIN_LEN_IPV4) begin
         v6 = 1'b0;
         ahi = '0;
         alo = {32'd0, alo[31:0]};
      end else if (etype == ETH_IPV6 && caplen >= MIN_LEN_IPV6) begin
         v6 = 1'b1;
      end else begin
         return t;
      end
      slot = -1;
      for (int i = 0; i < flows_used; i++) begin
         if (flow_table[i].is_v6 == v6 && flow_table[i].addr_hi == ahi &&
             flow_table[i].addr_lo == alo) begin
            slot = i;
            break;
         end
      end
      if (slot >= 0) begin
         t.status = ST_HIT;
      end else if (flows_used >= TABLE_ENTRIES) begin
         t.status = ST_FULL;
         return t;
      end else begin
         slot = flows_used;
         flows_used++;
         flow_table[slot] = '{is_v6: v6, addr_hi: ahi, addr_lo: alo,
                              packets: 64'd0, bytes: 64'd0, bucket: 32'd0};
         t.status = ST_NEW;
      end
      flow_table[slot].packets += 64'd1;
      flow_table[slot].bytes += {48'd0, plen};
      flow_table[slot].bucket = 32'(now / BUCKET_SPAN_NS);
      t.packets = flow_table[slot].packets;
      t.bytes = flow_table[slot].bytes;
      t.bucket = flow_table[slot].bucket;
      return t;
   endfunction

   always @(posedge clock) begin
      tally_type want;
      if (reset) begin
         flows_used = 0;
         tally_queue.delete();
         fail_count = 0;
         seen_counts = '{0, 0, 0, 0};
      end else begin
         if (req_valid && !req_stall)
            tally_queue.push_back(count_frame(req_ether_type, req_captured_len, req_src_addr_hi,
                                              req_src_addr_lo, req_packet_len, req_time_ns));
         if (rsp_valid && !rsp_stall) begin
            if (tally_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: result transfer with nothing expected");
            end else begin
               want = tally_queue.pop_front();
               seen_counts[rsp_status]++;
               if (rsp_status !== want.status || rsp_packet_count !== want.packets ||
                   rsp_byte_count !== want.bytes || rsp_time_bucket !== want.bucket) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp st=%0d pk=%h by=%h bk=%h got st=%0d pk=%h by=%h bk=%h",
                              want.status, want.packets, want.bytes, want.bucket, rsp_status,
                              rsp_packet_count, rsp_byte_count, rsp_time_bucket);
               end
            end
         end
      end
   end

endmodule

### sim/tb_per_source_ip_traffic_counter.sv
// tb_per_source_ip_traffic_counter: stimulus and verdict for the traffic counter.
// Depends on pstc_pkg, the block itself and pstc_scoreboard.
`timescale 1ns / 1ps
module tb_per_source_ip_traffic_counter;
   import pstc_pkg::*;

   localparam int RANDOM_FRAMES = 1250;
   localparam longint CYCLE_LIMIT = 64'd10000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_ether_type;
   logic [15:0] req_captured_len;
   logic [63:0] req_src_addr_hi;
   logic [63:0] req_src_addr_lo;
   logic [15:0] req_packet_len;
   logic [63:0] req_time_ns;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_packet_count;
   logic [63:0] rsp_byte_count;
   logic [31:0] rsp_time_bucket;

   int          fail_count;
   int          pending;
   int          seen_counts [4];
   longint      cycle_count;
   int          frames_sent;
   bit          long_holdoff;   // asks the receiver for one long stall
   bit          holdoff_done;

   // Pool of recurring sources so that hits are common; slot 0 of each is
   // the all-ones address to exercise the top bits.
   logic [63:0] v6_hi_pool [16];
   logic [63:0] v6_lo_pool [16];
   logic [31:0] v4_pool    [16];

   per_source_ip_traffic_counter i_dut (.*);

   pstc_scoreboard i_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung block ends the run as a failure.
   always @(posedge clock) begin
      if (reset)
         cycle_count <= 0;
      else
         cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("FAIL per_source_ip_traffic_counter");
         $finish;
      end
   end

   // Gap length: mostly zero or short, now and then long.
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request so the
   // 2-deep queue fills and req_stall rises.
   initial begin
      int n;
      rsp_stall = 1'b0;
      holdoff_done = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (long_holdoff && !holdoff_done) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            holdoff_done = 1'b1;
         end
         n = ($urandom_range(0, 3) == 0) ? gap_cycles() : 0;
         rsp_stall <= (n != 0);
         repeat (n) @(posedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // One transfer; valid stays high across back-to-back frames.
   task automatic send_frame(input logic [15:0] etype, input logic [15:0] caplen,
                             input logic [63:0] ahi, input logic [63:0] alo,
                             input logic [15:0] plen, input logic [63:0] now);
      int n;
      n = gap_cycles();
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_ether_type   <= etype;
      req_captured_len <= caplen;
      req_src_addr_hi  <= ahi;
      req_src_addr_lo  <= alo;
      req_packet_len   <= plen;
      req_time_ns      <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames_sent++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Time values over the full 64-bit range, plus bucket edges.
   function automatic logic [63:0] rand_time();
      case ($urandom_range(0, 3))
         0: return rand64();
         1: return 64'hFFFF_FFFF_FFFF_FFFF;
         2: return 64'({$urandom_range(0, 99)}) * BUCKET_SPAN_NS - 64'($urandom_range(0, 1));
         default: return {32'd0, $urandom()} * 64'd1000;
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int          kind;
      int          fresh_flows;
      int          fill_frames;
      logic [15:0] etype;
      logic [15:0] caplen;
      logic [63:0] ahi;
      logic [63:0] alo;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_ether_type   = '0;
      req_captured_len = '0;
      req_src_addr_hi  = '0;
      req_src_addr_lo  = '0;
      req_packet_len   = '0;
      req_time_ns      = '0;
      frames_sent      = 0;
      long_holdoff     = 1'b0;
      fresh_flows      = 0;
      for (int i = 0; i < 16; i++) begin
         v6_hi_pool[i] = (i == 0) ? '1 : rand64();
         v6_lo_pool[i] = (i == 0) ? '1 : rand64();
         v4_pool[i]    = (i == 0) ? '1 : $urandom();
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: length thresholds, short captures, IPv4 key masking,
      // zero and maximal lengths and times, non-IP types.
      send_frame(ETH_IPV4, MIN_LEN_IPV4, '1, 64'hFFFF_FFFF_0A00_0001, 16'hFFFF, '1);
      send_frame(ETH_IPV4, MIN_LEN_IPV4, '0, 64'h0000_0000_0A00_0001, 16'h0000, 64'd0);
      send_frame(ETH_IPV4, MIN_LEN_IPV4 - 16'd1, '0, 64'h0A00_0001, 16'd60, 64'd5);
      send_frame(ETH_IPV4, 16'hFFFF, 64'h1234, 64'h0, 16'd1, BUCKET_SPAN_NS - 64'd1);
      send_frame(ETH_IPV4, 16'hFFFF, 64'h0, 64'h5555_5555_0000_0000, 16'd1, BUCKET_SPAN_NS);
      send_frame(ETH_IPV6, MIN_LEN_IPV6, '1, '1, 16'hFFFF, '1);
      send_frame(ETH_IPV6, MIN_LEN_IPV6 - 16'd1, '1, '1, 16'd64, 64'd0);
      send_frame(ETH_IPV6, 16'hFFFF, '0, '0, 16'd0, 64'd0);
      send_frame(ETH_IPV6, 16'd100, '1, '1, 16'd1500, 64'd123456789012);
      // IPv6 address whose low 32 bits match an IPv4 entry: distinct flow.
      send_frame(ETH_IPV6, 16'd100, '0, 64'h0A00_0001, 16'd40, 64'd7);
      send_frame(ETH_IPV4, 16'd13, '0, 64'h0A00_0001, 16'd40, 64'd7);
      send_frame(ETH_IPV6, 16'd0, '0, '0, 16'd40, 64'd7);
      send_frame(16'h0806, 16'hFFFF, '1, '1, 16'd42, 64'd7);
      send_frame(16'hFFFF, 16'hFFFF, '1, '1, 16'hFFFF, '1);
      send_frame(16'h0000, 16'h0000, '0, '0, 16'h0000, '0);
      send_frame(16'h86DC, 16'd100, '1, '1, 16'd1, 64'd1);
      send_frame(16'h0801, 16'd100, '1, '1, 16'd1, 64'd1);
      send_frame(ETH_IPV4, 16'd34, '0, 64'h0A00_0001, 16'h8000, 64'd18446744069999999999);
      wait_drained();

      // Back pressure: the receiver holds off while frames keep coming.
      long_holdoff = 1'b1;
      for (int i = 0; i < 12; i++)
         send_frame(ETH_IPV4, 16'd64, '0, {32'd0, v4_pool[i % 4]}, 16'($urandom()), rand_time());
      wait (holdoff_done);
      wait_drained();

      // Random: mostly valid frames from a small pool (hits), some fresh
      // sources to grow the table, the rest noise.
      for (int i = 0; i < RANDOM_FRAMES; i++) begin
         kind = $urandom_range(0, 99);
         ahi  = rand64();
         alo  = rand64();
         if (kind < 40) begin
            etype  = ETH_IPV4;
            caplen = 16'($urandom_range(34, 65535));
            alo    = {alo[63:32], v4_pool[$urandom_range(0, 15)]};
         end else if (kind < 70) begin
            etype  = ETH_IPV6;
            caplen = 16'($urandom_range(54, 65535));
            ahi    = v6_hi_pool[$urandom_range(0, 15)];
            alo    = v6_lo_pool[$urandom_range(0, 15)];
         end else if (kind < 88) begin
            // Fresh source.
            etype  = $urandom_range(0, 1) ? ETH_IPV4 : ETH_IPV6;
            caplen = 16'($urandom_range(54, 65535));
            fresh_flows++;
         end else begin
            etype  = $urandom_range(0, 1) ? 16'($urandom()) :
                     ($urandom_range(0, 1) ? ETH_IPV4 : ETH_IPV6);
            caplen = 16'($urandom_range(0, 60));
         end
         send_frame(etype, caplen, ahi, alo, 16'($urandom()), rand_time());
         // Occasional full pause until every result is back.
         if (i % 500 == 250)
            wait_drained();
      end

      // Fill the table and go past full so a few dozen frames drop.
      wait_drained();
      fill_frames = TABLE_ENTRIES + 30 - seen_counts[ST_NEW];
      for (int i = 0; i < fill_frames; i++)
         send_frame(ETH_IPV6, 16'd80, rand64(), rand64(), 16'($urandom()), rand_time());
      send_frame(ETH_IPV4, 16'd80, '0, {32'd0, v4_pool[0]}, 16'd1, 64'd1);

      wait_drained();
      repeat (1100) @(posedge clock);
      $display("%0d frames sent: %0d ignored, %0d hits, %0d new flows, %0d dropped at full table",
               frames_sent, seen_counts[0], seen_counts[1], seen_counts[2], seen_counts[3]);
      $display("%0d mismatches", fail_count);
      if (fail_count == 0)
         $display("PASS per_source_ip_traffic_counter");
      else
         $display("FAIL per_source_ip_traffic_counter");
      $finish;
   end

endmodule

### sim.f
design/pstc_pkg.sv
design/pstc_front.sv
design/pstc_div.sv
design/pstc_back.sv
design/per_source_ip_traffic_counter.sv
sim/pstc_scoreboard.sv
sim/tb_per_source_ip_traffic_counter.sv
